// File: design/pdm_pkg.sv
// pdm_pkg: shared constants, register codes and bundle types of the motor drive
`timescale 1ns / 1ps
package pdm_pkg;

    // fixed-point and duty limits
    localparam int FRAC_BITS = 8;
    localparam int DUTY_MAX  = 1000;

    // field widths
    localparam int ERR_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int BOUND_W = 18;
    localparam int BASE_W  = 10;
    localparam int CTL_W   = 19;
    localparam int DUTY_W  = 10;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 18;

    // datapath widths
    localparam int SUM_W  = BOUND_W + 1;
    localparam int DIFF_W = ERR_W + 1;
    localparam int PP_W   = GAIN_W + ERR_W;
    localparam int PI_W   = GAIN_W + SUM_W;
    localparam int PD_W   = GAIN_W + DIFF_W;
    localparam int ACC_W  = PI_W + 2;
    localparam int DRV_W  = ((BASE_W + FRAC_BITS) > CTL_W ? (BASE_W + FRAC_BITS) : CTL_W) + 2;
    localparam int CMP_W  = 32;

    // register reset values
    localparam logic [BOUND_W-1:0] INTEGRAL_BOUND_RST = 18'd76800;
    localparam logic [BOUND_W-1:0] OUTPUT_BOUND_RST   = 18'd76800;
    localparam logic [BASE_W-1:0]  STRAIGHT_BASE_RST  = 10'd230;
    localparam logic [BASE_W-1:0]  CURVE_BASE_RST     = 10'd225;

    typedef enum logic [IDX_W-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_INTEGRAL_BOUND = 3'd3,
        REG_OUTPUT_BOUND   = 3'd4,
        REG_STRAIGHT_BASE  = 3'd5,
        REG_CURVE_BASE     = 3'd6
    } pdm_reg_e;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [BOUND_W-1:0] integral_bound;
        logic [BOUND_W-1:0] output_bound;
        logic [BASE_W-1:0]  straight_base;
        logic [BASE_W-1:0]  curve_base;
    } pdm_cfg_t;

    // pipeline stage loads
    typedef struct packed {
        logic s1_load;
        logic s2_load;
        logic s3_load;
    } pdm_ctrl_t;

    // integrator stage to control law stage
    typedef struct packed {
        logic [ERR_W-1:0]  error;
        logic [SUM_W-1:0]  sum;
        logic [DIFF_W-1:0] diff;
        logic              curve;
    } pdm_s1_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              forward;
    } pdm_cmd_t;

    typedef struct packed {
        logic [CTL_W-1:0]  control_out;
        logic [DUTY_W-1:0] left_duty;
        logic              left_forward;
        logic [DUTY_W-1:0] right_duty;
        logic              right_forward;
        logic              left_rejected;
        logic              right_rejected;
    } pdm_result_t;

endpackage

// File: design/pid_differential_motor_drive.sv
// pid_differential_motor_drive: top level of the PID steering differential motor drive
`timescale 1ns / 1ps
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-----------------------
//  cfg     | cfg_we, cfg_index, cfg_wdata              | write on cfg_we, no wait
//  in      | steer_error, curve_mode                   | in_valid / in_ready
//  out     | control_out, left/right duty, forward,    | out_valid / out_ready
//          | left_rejected, right_rejected             |
//
//  Three register stages (input, gain products, result) carry each
//  transaction to the output; one transaction per cycle is sustained while
//  out_ready is high. Error sum and previous error update at input
//  acceptance, the motor commands at the result load.
//  Reset clears sum, previous error, both commands (stopped, forward) and all
//  stage valids; config returns to its defaults. A stall on out_ready holds
//  each full stage; in_ready drops only with all stages full and out_ready low.
//
module pid_differential_motor_drive
    import pdm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [ERR_W-1:0] steer_error,
    input  logic                    curve_mode,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [CTL_W-1:0] control_out,
    output logic [DUTY_W-1:0]       left_duty,
    output logic                    left_forward,
    output logic [DUTY_W-1:0]       right_duty,
    output logic                    right_forward,
    output logic                    left_rejected,
    output logic                    right_rejected
);

    pdm_cfg_t    cfg;
    pdm_ctrl_t   ctrl;
    pdm_s1_t     s1;
    pdm_result_t res;

    // stage valids
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic en1, en2, en3;

    // a stage may load when it is empty or its contents move on this cycle
    always_comb
    begin
        en3 = !v3_reg || out_ready;
        en2 = !v2_reg || en3;
        en1 = !v1_reg || en2;

        ctrl.s1_load = in_valid && en1;
        ctrl.s2_load = v1_reg && en2;
        ctrl.s3_load = v2_reg && en3;

        v1_next = en1 ? in_valid : v1_reg;
        v2_next = en2 ? v1_reg : v2_reg;
        v3_next = en3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    pdm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pdm_integrator u_integ (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .steer_error    (steer_error),
        .curve_mode     (curve_mode),
        .integral_bound (cfg.integral_bound),
        .s1             (s1)
    );

    pdm_control_law u_law (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .s1    (s1),
        .cfg   (cfg),
        .res   (res)
    );

    assign in_ready       = en1;
    assign out_valid      = v3_reg;
    assign control_out    = res.control_out;
    assign left_duty      = res.left_duty;
    assign left_forward   = res.left_forward;
    assign right_duty     = res.right_duty;
    assign right_forward  = res.right_forward;
    assign left_rejected  = res.left_rejected;
    assign right_rejected = res.right_rejected;

    // backpressure reaches the input only with every stage full
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && !out_ready))
        else $error("input stalled with an empty stage");

    // clamped output never exceeds the output bound
    a_ctl_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((CTL_W + 1)'(control_out) <= $signed({2'b00, cfg.output_bound})
                    && (CTL_W + 1)'(control_out) >= -$signed({2'b00, cfg.output_bound})))
        else $error("control_out outside output bound");

    // a transaction entering the result register is presented next cycle
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.s3_load |=> out_valid)
        else $error("result load without out_valid");

endmodule

// File: design/pdm_cfg_regs.sv
// pdm_cfg_regs: configuration register file of the motor drive
`timescale 1ns / 1ps
module pdm_cfg_regs
    import pdm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    output pdm_cfg_t         cfg
);

    pdm_cfg_t cfg_reg;
    pdm_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_P:         cfg_next.gain_p         = cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I:         cfg_next.gain_i         = cfg_wdata[GAIN_W-1:0];
                REG_GAIN_D:         cfg_next.gain_d         = cfg_wdata[GAIN_W-1:0];
                REG_INTEGRAL_BOUND: cfg_next.integral_bound = cfg_wdata[BOUND_W-1:0];
                REG_OUTPUT_BOUND:   cfg_next.output_bound   = cfg_wdata[BOUND_W-1:0];
                REG_STRAIGHT_BASE:  cfg_next.straight_base  = cfg_wdata[BASE_W-1:0];
                REG_CURVE_BASE:     cfg_next.curve_base     = cfg_wdata[BASE_W-1:0];
                default:            cfg_next = cfg_reg;   // unmapped index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= '0;
            cfg_reg.gain_i         <= '0;
            cfg_reg.gain_d         <= '0;
            cfg_reg.integral_bound <= INTEGRAL_BOUND_RST;
            cfg_reg.output_bound   <= OUTPUT_BOUND_RST;
            cfg_reg.straight_base  <= STRAIGHT_BASE_RST;
            cfg_reg.curve_base     <= CURVE_BASE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/pdm_integrator.sv
// pdm_integrator: clamped error sum, error difference and input stage register
`timescale 1ns / 1ps
module pdm_integrator
    import pdm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  pdm_ctrl_t          ctrl,
    input  logic [ERR_W-1:0]   steer_error,
    input  logic               curve_mode,
    input  logic [BOUND_W-1:0] integral_bound,
    output pdm_s1_t            s1
);

    logic signed [SUM_W-1:0] error_sum_reg;
    logic signed [SUM_W-1:0] error_sum_next;
    logic [ERR_W-1:0]        prev_error_reg;
    pdm_s1_t                 s1_reg;
    pdm_s1_t                 s1_next;

    logic signed [SUM_W:0]    sum_raw;
    logic signed [SUM_W:0]    bound_s;
    logic signed [DIFF_W-1:0] diff;

    always_comb
    begin
        sum_raw = (SUM_W + 1)'(error_sum_reg) + (SUM_W + 1)'($signed(steer_error));
        bound_s = $signed({2'b00, integral_bound});
        if (sum_raw > bound_s)
            error_sum_next = SUM_W'(bound_s);
        else if (sum_raw < -bound_s)
            error_sum_next = SUM_W'(-bound_s);
        else
            error_sum_next = SUM_W'(sum_raw);

        diff = DIFF_W'($signed(steer_error)) - DIFF_W'($signed(prev_error_reg));

        s1_next.error = steer_error;
        s1_next.sum   = error_sum_next;
        s1_next.diff  = diff;
        s1_next.curve = curve_mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            prev_error_reg <= '0;
        end
        else if (ctrl.s1_load)
        begin
            error_sum_reg  <= error_sum_next;
            prev_error_reg <= steer_error;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_load)
            s1_reg <= s1_next;
    end

    assign s1 = s1_reg;

endmodule

// File: design/pdm_control_law.sv
// pdm_control_law: gain products, output clamp, motor drives and command state
`timescale 1ns / 1ps
module pdm_control_law
    import pdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pdm_ctrl_t   ctrl,
    input  pdm_s1_t     s1,
    input  pdm_cfg_t    cfg,
    output pdm_result_t res
);

    localparam logic signed [CMP_W-1:0] DUTY_LIM = CMP_W'(DUTY_MAX);

    // product stage
    logic signed [PP_W-1:0] p_prod_reg;
    logic signed [PI_W-1:0] i_prod_reg;
    logic signed [PD_W-1:0] d_prod_reg;
    logic                   curve_reg;

    // command state and result
    pdm_cmd_t    left_cmd_reg,  left_cmd_next;
    pdm_cmd_t    right_cmd_reg, right_cmd_next;
    pdm_result_t res_reg, res_next;

    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] lim;
    logic signed [ACC_W-1:0] acc_c;
    logic signed [ACC_W-1:0] acc_bias;
    logic signed [ACC_W-1:0] ctl_full;
    logic signed [CTL_W-1:0] ctl;
    logic signed [DRV_W-1:0] base_s;
    logic signed [DRV_W-1:0] left_drive;
    logic signed [DRV_W-1:0] right_drive;
    logic                    left_rej;
    logic                    right_rej;

    // divide by 2^FRAC_BITS, truncating toward zero
    function automatic logic signed [DRV_W-1:0] drive_div(input logic signed [DRV_W-1:0] x);
        logic signed [DRV_W-1:0] bias;
        bias = x[DRV_W-1] ? DRV_W'((1 << FRAC_BITS) - 1) : '0;
        return (x + bias) >>> FRAC_BITS;
    endfunction

    function automatic logic drive_bad(input logic signed [DRV_W-1:0] d);
        logic signed [CMP_W-1:0] dx;
        dx = CMP_W'(d);
        return (dx > DUTY_LIM) || (dx < -DUTY_LIM);
    endfunction

    function automatic pdm_cmd_t drive_cmd(input logic signed [DRV_W-1:0] d);
        pdm_cmd_t                c;
        logic signed [DRV_W-1:0] mag;
        mag       = d[DRV_W-1] ? -d : d;
        c.duty    = DUTY_W'(mag);
        c.forward = ~d[DRV_W-1];
        return c;
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctrl.s2_load)
        begin
            p_prod_reg <= $signed(cfg.gain_p) * $signed(s1.error);
            i_prod_reg <= $signed(cfg.gain_i) * $signed(s1.sum);
            d_prod_reg <= $signed(cfg.gain_d) * $signed(s1.diff);
            curve_reg  <= s1.curve;
        end
    end

    always_comb
    begin
        acc = ACC_W'(p_prod_reg) + ACC_W'(i_prod_reg) + ACC_W'(d_prod_reg);
        lim = $signed(ACC_W'(cfg.output_bound)) <<< FRAC_BITS;
        if (acc > lim)
            acc_c = lim;
        else if (acc < -lim)
            acc_c = -lim;
        else
            acc_c = acc;
        acc_bias = acc_c[ACC_W-1] ? ACC_W'((1 << FRAC_BITS) - 1) : '0;
        ctl_full = (acc_c + acc_bias) >>> FRAC_BITS;
        ctl      = CTL_W'(ctl_full);

        base_s = $signed(DRV_W'(curve_reg ? cfg.curve_base : cfg.straight_base)) <<< FRAC_BITS;
        left_drive  = drive_div(base_s + DRV_W'(ctl));
        right_drive = drive_div(base_s - DRV_W'(ctl));
        left_rej    = drive_bad(left_drive);
        right_rej   = drive_bad(right_drive);

        // a rejected drive stops its motor in curve mode and holds the last command otherwise
        if (!left_rej)
            left_cmd_next = drive_cmd(left_drive);
        else if (curve_reg)
            left_cmd_next = '{duty: '0, forward: 1'b1};
        else
            left_cmd_next = left_cmd_reg;

        if (!right_rej)
            right_cmd_next = drive_cmd(right_drive);
        else if (curve_reg)
            right_cmd_next = '{duty: '0, forward: 1'b1};
        else
            right_cmd_next = right_cmd_reg;

        res_next.control_out    = ctl;
        res_next.left_duty      = left_cmd_next.duty;
        res_next.left_forward   = left_cmd_next.forward;
        res_next.right_duty     = right_cmd_next.duty;
        res_next.right_forward  = right_cmd_next.forward;
        res_next.left_rejected  = left_rej;
        res_next.right_rejected = right_rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_cmd_reg  <= '{duty: '0, forward: 1'b1};
            right_cmd_reg <= '{duty: '0, forward: 1'b1};
        end
        else if (ctrl.s3_load)
        begin
            left_cmd_reg  <= left_cmd_next;
            right_cmd_reg <= right_cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s3_load)
            res_reg <= res_next;
    end

    assign res = res_reg;

    // rejected motor in curve mode ends stopped
    a_curve_reject_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.s3_load && curve_reg && left_rej)
        |=> (left_cmd_reg.duty == '0 && left_cmd_reg.forward))
        else $error("left motor not stopped after curve-mode rejection");

    // commands only move when a transaction leaves the last stage
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.s3_load |=> ($stable(left_cmd_reg) && $stable(right_cmd_reg)))
        else $error("motor command changed without a transaction");

endmodule
